// File: rtl/gepc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gepc_pkg
// shared constants and types for the grid exit path counter
// ----------------------------------------------------------------------------
package gepc_pkg;

  localparam int MAX_DIM_DEF   = 64;
  localparam int MAX_MOVES_DEF = 64;

  localparam int CFG_W   = 7;
  localparam int COORD_W = 6;
  localparam int COUNT_W = 30;

  localparam logic [COUNT_W-1:0] PATH_MOD = 30'd1000000007;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_ROWS  = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS  = 2'd1;
  localparam logic [1:0] CFG_MOVE_LIMIT = 2'd2;

  // neighbor order used by the cell sequencer
  localparam logic [1:0] NB_LEFT  = 2'd0;
  localparam logic [1:0] NB_RIGHT = 2'd1;
  localparam logic [1:0] NB_UP    = 2'd2;
  localparam logic [1:0] NB_DOWN  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_LAST = 5'b00100,
    ST_RES  = 5'b01000,
    ST_PUSH = 5'b10000
  } gepc_state_t;

endpackage
`default_nettype wire

// File: rtl/gepc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gepc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gepc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/grid_exit_path_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_exit_path_counter
// counts move sequences that carry a ball off a grid, modulo 1000000007
// ----------------------------------------------------------------------------
// Each input beat names a start cell; the block answers with one output beat
// holding the number of paths of at most move_limit steps that leave the
// grid_rows by grid_cols grid from that cell, modulo 1000000007. Rows and
// columns of 0 count as 1 and saturate at MAX_DIM, move_limit saturates at
// MAX_MOVES; a start cell outside the grid or a move limit of 0 gives 0.
// The work runs one layer per move over two ping-pong layer rams, one cell
// after another, on a single modular adder fed by the one ram read port:
// each cell runs four neighbor reads in ST_CALC, then one closing add and
// write in ST_LAST. No clearing pass is needed: the first layer never reads
// the rams. in_stall is high from accept until the result is loaded into the
// output register; a new request is taken while that result still waits on
// out_stall.
// ----------------------------------------------------------------------------
module grid_exit_path_counter #(
  parameter int MAX_DIM   = gepc_pkg::MAX_DIM_DEF,
  parameter int MAX_MOVES = gepc_pkg::MAX_MOVES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [gepc_pkg::CFG_W-1:0]    cfg_data,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [gepc_pkg::COORD_W-1:0]  in_start_row,
  input  wire logic [gepc_pkg::COORD_W-1:0]  in_start_col,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [gepc_pkg::COUNT_W-1:0]  out_path_count
);

  import gepc_pkg::*;

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * DIM_W;
  localparam int DEPTH = 1 << AW;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int MOV_W = $clog2(MAX_MOVES + 1);

  // configuration registers
  logic [CFG_W-1:0] grid_rows_r;
  logic [CFG_W-1:0] grid_cols_r;
  logic [CFG_W-1:0] move_limit_r;

  // sequencer state
  gepc_state_t      state_r;
  logic [DIM_W-1:0] i_r;
  logic [DIM_W-1:0] j_r;
  logic [1:0]       d_r;
  logic [MOV_W-1:0] layer_r;
  logic             wsel_r;
  logic             zero_r;
  logic [AW-1:0]    sa_r;
  logic             ext_r;
  logic             ram_r;
  logic [COUNT_W-1:0] acc_r;

  // output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;

  // effective sizes after clamping
  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] cols_eff;
  logic [MOV_W-1:0] moves_eff;

  always_comb begin
    if (grid_rows_r == '0) begin
      rows_eff = CNT_W'(1);
    end else if (32'(grid_rows_r) > MAX_DIM) begin
      rows_eff = CNT_W'(MAX_DIM);
    end else begin
      rows_eff = CNT_W'(grid_rows_r);
    end
    if (grid_cols_r == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(grid_cols_r) > MAX_DIM) begin
      cols_eff = CNT_W'(MAX_DIM);
    end else begin
      cols_eff = CNT_W'(grid_cols_r);
    end
    if (32'(move_limit_r) > MAX_MOVES) begin
      moves_eff = MOV_W'(MAX_MOVES);
    end else begin
      moves_eff = MOV_W'(move_limit_r);
    end
  end

  // handshakes
  logic in_acc;
  logic slot_free;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  logic start_out;
  assign start_out = (32'(in_start_row) >= 32'(rows_eff)) ||
                     (32'(in_start_col) >= 32'(cols_eff));

  // grid edges around the current cell
  logic i_last;
  logic j_last;
  logic row_last;
  logic layer_last;
  assign i_last     = (CNT_W'(i_r) + CNT_W'(1)) == rows_eff;
  assign j_last     = (CNT_W'(j_r) + CNT_W'(1)) == cols_eff;
  assign row_last   = i_last && j_last;
  assign layer_last = (layer_r + MOV_W'(1)) == moves_eff;

  // neighbor selection for this cycle
  logic          nb_ext;
  logic [AW-1:0] nb_addr;
  always_comb begin
    case (d_r)
      NB_LEFT: begin
        nb_ext  = (j_r == '0);
        nb_addr = {i_r, j_r - DIM_W'(1)};
      end
      NB_RIGHT: begin
        nb_ext  = j_last;
        nb_addr = {i_r, j_r + DIM_W'(1)};
      end
      NB_UP: begin
        nb_ext  = (i_r == '0);
        nb_addr = {i_r - DIM_W'(1), j_r};
      end
      NB_DOWN: begin
        nb_ext  = i_last;
        nb_addr = {i_r + DIM_W'(1), j_r};
      end
      default: begin
        nb_ext  = 1'b0;
        nb_addr = '0;
      end
    endcase
  end

  // layer rams, written on one side and read on the other
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               we;
  logic [COUNT_W-1:0] rd0;
  logic [COUNT_W-1:0] rd1;
  logic [COUNT_W-1:0] rd_data;

  assign raddr   = (state_r == ST_CALC) ? nb_addr : sa_r;
  assign waddr   = {i_r, j_r};
  assign we      = (state_r == ST_LAST);
  assign rd_data = wsel_r ? rd0 : rd1;

  // shared modular adder: the term is 1 off the grid, else 0 on the first layer and the ram read data after
  logic [COUNT_W-1:0] term;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W:0]   diff;
  logic [COUNT_W-1:0] acc_add;
  always_comb begin
    if (ext_r) begin
      term = COUNT_W'(1);
    end else if (ram_r) begin
      term = rd_data;
    end else begin
      term = '0;
    end
    sum     = {1'b0, acc_r} + {1'b0, term};
    diff    = sum - {1'b0, PATH_MOD};
    acc_add = (sum >= {1'b0, PATH_MOD}) ? diff[COUNT_W-1:0] : sum[COUNT_W-1:0];
  end

  gepc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_bank0 (
    .clk   (clk),
    .we    (we && !wsel_r),
    .waddr (waddr),
    .wdata (acc_add),
    .raddr (raddr),
    .rdata (rd0)
  );

  gepc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_bank1 (
    .clk   (clk),
    .we    (we && wsel_r),
    .waddr (waddr),
    .wdata (acc_add),
    .raddr (raddr),
    .rdata (rd1)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= CFG_W'(1);
      grid_cols_r  <= CFG_W'(1);
      move_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_ROWS:  grid_rows_r  <= cfg_data;
        CFG_GRID_COLS:  grid_cols_r  <= cfg_data;
        CFG_MOVE_LIMIT: move_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  gepc_state_t      state_nxt;
  logic [DIM_W-1:0] i_nxt;
  logic [DIM_W-1:0] j_nxt;
  logic [1:0]       d_nxt;
  logic [MOV_W-1:0] layer_nxt;
  logic             wsel_nxt;
  logic             zero_nxt;
  logic [AW-1:0]    sa_nxt;
  logic             ext_nxt;
  logic             ram_nxt;
  logic [COUNT_W-1:0] acc_nxt;
  logic               out_valid_nxt;
  logic [COUNT_W-1:0] out_count_nxt;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    d_nxt         = d_r;
    layer_nxt     = layer_r;
    wsel_nxt      = wsel_r;
    zero_nxt      = zero_r;
    sa_nxt        = sa_r;
    ext_nxt       = ext_r;
    ram_nxt       = ram_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sa_nxt    = {DIM_W'(in_start_row), DIM_W'(in_start_col)};
          i_nxt     = '0;
          j_nxt     = '0;
          d_nxt     = NB_LEFT;
          layer_nxt = '0;
          if (start_out || moves_eff == '0) begin
            zero_nxt  = 1'b1;
            state_nxt = ST_PUSH;
          end else begin
            zero_nxt  = 1'b0;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        // issue one neighbor read, fold in the previous one (the left read clears the accumulator instead)
        acc_nxt = (d_r == NB_LEFT) ? '0 : acc_add;
        ext_nxt = nb_ext;
        ram_nxt = !nb_ext && (layer_r != '0);
        d_nxt   = d_r + 2'd1;
        if (d_r == NB_DOWN) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        // last neighbor folded in, cell written this cycle
        if (j_last) begin
          j_nxt = '0;
          i_nxt = i_last ? '0 : i_r + DIM_W'(1);
        end else begin
          j_nxt = j_r + DIM_W'(1);
        end
        if (row_last) begin
          layer_nxt = layer_r + MOV_W'(1);
          wsel_nxt  = !wsel_r;
          state_nxt = layer_last ? ST_RES : ST_CALC;
        end else begin
          state_nxt = ST_CALC;
        end
      end
      ST_RES: begin
        // start cell read issued from the last written bank
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = zero_r ? '0 : rd_data;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      d_r         <= NB_LEFT;
      layer_r     <= '0;
      wsel_r      <= 1'b0;
      zero_r      <= 1'b0;
      ext_r       <= 1'b0;
      ram_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      d_r         <= d_nxt;
      layer_r     <= layer_nxt;
      wsel_r      <= wsel_nxt;
      zero_r      <= zero_nxt;
      ext_r       <= ext_nxt;
      ram_r       <= ram_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sa_r        <= sa_nxt;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_path_count = out_count_r;

  // checks
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_path_count < PATH_MOD))
    else $error("result beat holds a count not reduced modulo the prime");

  a_write_in_last: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (!zero_r && layer_r < moves_eff))
    else $error("layer ram written outside a running layer sweep");

  a_push_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && slot_free) |=> (out_valid && state_r == ST_IDLE))
    else $error("finished result not loaded into the output register");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request accepted without the sequencer leaving idle");

endmodule
`default_nettype wire
